@@ design/jaos_pkg.sv @@
// Shared constants and types for the JSON array object splitter.
package jaos_pkg;

   localparam int BYTE_W  = 8;
   localparam int CFG_W   = 7;
   localparam int INDEX_W = 6;

   localparam int MAX_ELEMENTS_DEFAULT = 64;
   localparam int MAX_DEPTH_DEFAULT    = 127;

   localparam logic [CFG_W-1:0] MAX_COUNT_RESET = CFG_W'(64);

   localparam logic [BYTE_W-1:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [BYTE_W-1:0] CHAR_RBRACKET  = 8'h5D;
   localparam logic [BYTE_W-1:0] CHAR_LBRACE    = 8'h7B;
   localparam logic [BYTE_W-1:0] CHAR_RBRACE    = 8'h7D;
   localparam logic [BYTE_W-1:0] CHAR_QUOTE     = 8'h22;
   localparam logic [BYTE_W-1:0] CHAR_BACKSLASH = 8'h5C;

   typedef struct packed {
      logic [BYTE_W-1:0]  text_byte;
      logic               first;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  byte_out;
      logic               in_element;
      logic               element_start;
      logic               element_end;
      logic [INDEX_W-1:0] element_index;
      logic               scan_done;
   } rsp_type;

endpackage

@@ design/jaos_in_stage.sv @@
// Input register that holds one request until the scanner takes it.
module jaos_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  jaos_pkg::req_type req_data,
   input  logic              advance,
   output logic              req_stall,
   output logic              item_valid,
   output jaos_pkg::req_type item_data
);
   import jaos_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   assign req_stall  = valid_ff && !advance;
   assign valid_in   = req_stall ? valid_ff : req_valid;
   assign item_valid = valid_ff;
   assign item_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         data_ff <= req_data;
      end
   end

endmodule

@@ design/jaos_scan_core.sv @@
// Scan state and the per-byte logic that marks array elements.
module jaos_scan_core #(
   parameter int MAX_ELEMENTS = jaos_pkg::MAX_ELEMENTS_DEFAULT,
   parameter int MAX_DEPTH    = jaos_pkg::MAX_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  jaos_pkg::req_type          item_data,
   input  logic [jaos_pkg::CFG_W-1:0] max_count,
   output jaos_pkg::rsp_type          result
);
   import jaos_pkg::*;

   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int DEP_W = $clog2(MAX_DEPTH + 1) + 1;
   localparam logic signed [DEP_W-1:0] DEPTH_HI = DEP_W'(MAX_DEPTH);
   localparam logic signed [DEP_W-1:0] DEPTH_LO = -DEP_W'(MAX_DEPTH);

   typedef enum logic [1:0] {
      PH_WAIT,
      PH_SCAN,
      PH_DONE
   } phase_type;

   phase_type               phase_ff, phase_in, phase_cur;
   logic                    string_ff, string_in, string_cur;
   logic                    escape_ff, escape_in, escape_cur;
   logic signed [DEP_W-1:0] depth_ff, depth_in, depth_cur;
   logic                    open_ff, open_in, open_cur;
   logic [CNT_W-1:0]        count_ff, count_in, count_cur;
   logic [LIM_W-1:0]        limit;
   logic [LIM_W-1:0]        count_wide;
   logic [LIM_W-1:0]        count_next_wide;
   logic [BYTE_W-1:0]       c;
   logic                    in_el, st, en;

   assign c = item_data.text_byte;
   assign limit = (LIM_W'(max_count) < LIM_W'(MAX_ELEMENTS)) ?
                  LIM_W'(max_count) : LIM_W'(MAX_ELEMENTS);

   always_comb begin
      if (item_data.first) begin
         phase_cur  = PH_WAIT;
         string_cur = 1'b0;
         escape_cur = 1'b0;
         depth_cur  = '0;
         open_cur   = 1'b0;
         count_cur  = '0;
      end else begin
         phase_cur  = phase_ff;
         string_cur = string_ff;
         escape_cur = escape_ff;
         depth_cur  = depth_ff;
         open_cur   = open_ff;
         count_cur  = count_ff;
      end
      count_wide      = LIM_W'(count_cur);
      count_next_wide = count_wide + LIM_W'(1);

      phase_in  = phase_cur;
      string_in = string_cur;
      escape_in = escape_cur;
      depth_in  = depth_cur;
      open_in   = open_cur;
      count_in  = count_cur;
      in_el     = 1'b0;
      st        = 1'b0;
      en        = 1'b0;

      case (phase_cur)
         PH_WAIT: begin
            if (c == CHAR_LBRACKET) begin
               phase_in = PH_SCAN;
            end
         end
         PH_SCAN: begin
            if (count_wide >= limit) begin
               phase_in = PH_DONE;
            end else begin
               in_el = open_cur;
               if (string_cur) begin
                  if (escape_cur) begin
                     escape_in = 1'b0;
                  end else if (c == CHAR_BACKSLASH) begin
                     escape_in = 1'b1;
                  end else if (c == CHAR_QUOTE) begin
                     string_in = 1'b0;
                  end
               end else if (c == CHAR_QUOTE) begin
                  string_in = 1'b1;
               end else if (c == CHAR_LBRACE) begin
                  if (depth_cur == '0) begin
                     open_in = 1'b1;
                     in_el   = 1'b1;
                     st      = 1'b1;
                  end
                  if (depth_cur < DEPTH_HI) begin
                     depth_in = depth_cur + DEP_W'(1);
                  end
               end else if (c == CHAR_RBRACE) begin
                  if (depth_cur > DEPTH_LO) begin
                     depth_in = depth_cur - DEP_W'(1);
                  end
                  if (depth_in == '0 && open_cur) begin
                     open_in  = 1'b0;
                     en       = 1'b1;
                     in_el    = 1'b1;
                     count_in = count_cur + CNT_W'(1);
                     if (count_next_wide >= limit) begin
                        phase_in = PH_DONE;
                     end
                  end
               end else if (c == CHAR_RBRACKET && depth_cur == '0) begin
                  phase_in = PH_DONE;
               end
            end
         end
         default: begin
         end
      endcase

      result.byte_out      = c;
      result.in_element    = in_el;
      result.element_start = st;
      result.element_end   = en;
      result.element_index = in_el ? count_wide[INDEX_W-1:0] : '0;
      result.scan_done     = (phase_in == PH_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT;
         string_ff <= 1'b0;
         escape_ff <= 1'b0;
         depth_ff  <= '0;
         open_ff   <= 1'b0;
         count_ff  <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         string_ff <= string_in;
         escape_ff <= escape_in;
         depth_ff  <= depth_in;
         open_ff   <= open_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ design/jaos_out_stage.sv @@
// Result register that presents one response until the consumer takes it.
module jaos_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  jaos_pkg::rsp_type result,
   input  logic              rsp_stall,
   output logic              ready,
   output logic              rsp_valid,
   output jaos_pkg::rsp_type rsp_data
);
   import jaos_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign ready     = !valid_ff || !rsp_stall;
   assign valid_in  = ready ? fire : valid_ff;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         data_ff <= result;
      end
   end

endmodule

@@ design/json_array_object_splitter.sv @@
// Top level of the JSON array object splitter.
// The block takes one byte of JSON text per request and returns one response per byte: the
// byte itself, flags that mark the top-level objects of the first array, the element index
// and a done flag. A request passes through an input register and, once the result
// register can take it, the scan logic updates its state and loads the result register,
// so one byte is taken every cycle while rsp_stall is low. The scan state forms a loop
// over the brace depth and element count. A request with first set starts a new document.
// max_count may be written only while idle.
module json_array_object_splitter #(
   parameter int MAX_ELEMENTS = jaos_pkg::MAX_ELEMENTS_DEFAULT,
   parameter int MAX_DEPTH    = jaos_pkg::MAX_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [jaos_pkg::BYTE_W-1:0]  req_text_byte,
   input  logic                         req_first,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [jaos_pkg::BYTE_W-1:0]  rsp_byte_out,
   output logic                         rsp_in_element,
   output logic                         rsp_element_start,
   output logic                         rsp_element_end,
   output logic [jaos_pkg::INDEX_W-1:0] rsp_element_index,
   output logic                         rsp_scan_done,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [jaos_pkg::CFG_W-1:0]   csr_max_count
);
   import jaos_pkg::*;

   logic [CFG_W-1:0] max_count_val_ff;
   logic             item_valid;
   logic             out_ready;
   logic             fire;
   req_type          req_data;
   req_type          item_data;
   rsp_type          result;
   rsp_type          rsp_data;

   assign csr_ready = 1'b1;
   assign req_data.text_byte = req_text_byte;
   assign req_data.first     = req_first;
   assign fire = item_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_count_val_ff <= MAX_COUNT_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            max_count_val_ff <= csr_max_count;
         end
      end
   end

   jaos_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .advance    (out_ready),
      .req_stall  (req_stall),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   jaos_scan_core #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .MAX_DEPTH    (MAX_DEPTH)
   ) u_scan_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item_data (item_data),
      .max_count (max_count_val_ff),
      .result    (result)
   );

   jaos_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .result    (result),
      .rsp_stall (rsp_stall),
      .ready     (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_byte_out      = rsp_data.byte_out;
   assign rsp_in_element    = rsp_data.in_element;
   assign rsp_element_start = rsp_data.element_start;
   assign rsp_element_end   = rsp_data.element_end;
   assign rsp_element_index = rsp_data.element_index;
   assign rsp_scan_done     = rsp_data.scan_done;

endmodule
